// ===== rtl/core/smir_pkg.sv =====
package smir_pkg;

  localparam int MaxSegments = 64;
  localparam int MaxWords = 1024;

  localparam int ReqW = 3;
  localparam int IdW = 6;
  localparam int OffW = 10;
  localparam int SizeW = 11;
  localparam int WordW = 32;
  localparam int StatW = 3;

  localparam logic [ReqW-1:0] ReqMap = 3'd0;
  localparam logic [ReqW-1:0] ReqUnmap = 3'd1;
  localparam logic [ReqW-1:0] ReqLoad = 3'd2;
  localparam logic [ReqW-1:0] ReqStore = 3'd3;
  localparam logic [ReqW-1:0] ReqDup = 3'd4;
  localparam logic [ReqW-1:0] ReqAppend = 3'd5;

  localparam logic [StatW-1:0] StOk = 3'd0;
  localparam logic [StatW-1:0] StNoId = 3'd1;
  localparam logic [StatW-1:0] StUnmapped = 3'd2;
  localparam logic [StatW-1:0] StRange = 3'd3;
  localparam logic [StatW-1:0] StTooLarge = 3'd4;

  typedef struct packed {
    logic [ReqW-1:0] req;
    logic [IdW-1:0] seg_id;
    logic [IdW-1:0] dest_id;
    logic [OffW-1:0] offset;
    logic [SizeW-1:0] size;
    logic [WordW-1:0] value;
  } req_t;

endpackage

// ===== rtl/core/segment_memory_with_id_recycling_top.sv =====
// Segmented word memory with recycled segment IDs.
// Requests enter on the req channel (req_valid_i/req_ready_o) and each gives
// exactly one beat on the res channel (res_valid_o/res_ready_i).
// A two-entry request queue decouples the input side from the engine, so a
// new beat is taken while the engine works or a result waits, if the queue has room.
// The engine takes a request in its idle state, looking up its segment length
// and free stack top, then decides it in the evaluate state. Unmap, store, append,
// unused codes and all errors finish there; a load also passes a read state,
// because the word memory has a registered read port.
// Map zero-fills one word per cycle; duplicate copies each word with a read state
// and then a write state.
// A simple request goes through the queue, the request register and the result register.
// At reset only segment 0 is mapped with length zero, the free stack is empty
// and the next fresh ID is one; the word memory is not cleared.
// When the receiver stalls, the result holds and the engine takes no new
// request until the beat is accepted, while the queue keeps filling.
module segment_memory_with_id_recycling_top
  import smir_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  logic [ReqW-1:0] req_type_i,
  input  logic [IdW-1:0] seg_id_i,
  input  logic [IdW-1:0] dest_id_i,
  input  logic [OffW-1:0] offset_i,
  input  logic [SizeW-1:0] size_i,
  input  logic [WordW-1:0] value_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output logic [WordW-1:0] read_word_o,
  output logic [IdW-1:0] new_id_o,
  output logic [StatW-1:0] status_o
);

  req_t in_req, q_req;
  logic q_valid, q_ready;

  assign in_req = '{req: req_type_i, seg_id: seg_id_i, dest_id: dest_id_i,
                    offset: offset_i, size: size_i, value: value_i};

  smir_req_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i(req_valid_i), .in_ready_o(req_ready_o), .in_data_i(in_req),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_data_o(q_req)
  );

  smir_engine u_engine (
    .clk_i, .rst_ni,
    .req_valid_i(q_valid), .req_ready_o(q_ready), .req_i(q_req),
    .res_valid_o, .res_ready_i, .read_word_o, .new_id_o, .status_o
  );

endmodule

// ===== rtl/core/smir_req_fifo.sv =====
module smir_req_fifo
  import smir_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output req_t out_data_o
);

  req_t mem_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;

  assign in_ready_o = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mem_q[wr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (in_valid_i && in_ready_o) wr_q <= ~wr_q;
      if (out_valid_o && out_ready_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, in_valid_i && in_ready_o} - {1'b0, out_valid_o && out_ready_i};
    end
  end

endmodule

// ===== rtl/core/smir_engine.sv =====
module smir_engine
  import smir_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output logic [WordW-1:0] read_word_o,
  output logic [IdW-1:0] new_id_o,
  output logic [StatW-1:0] status_o
);

  localparam int SegW = $clog2(MaxSegments);
  localparam int WrdW = (MaxWords > 1) ? $clog2(MaxWords) : 1;
  localparam int AddrW = SegW + WrdW;
  localparam int CntW = $clog2(MaxSegments + 1);
  localparam int LenW = $clog2(MaxWords + 1);
  localparam int Depth = MaxSegments * (2 ** WrdW);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SEval = 3'd1;
  localparam logic [2:0] SRead = 3'd2;
  localparam logic [2:0] SZero = 3'd3;
  localparam logic [2:0] SCopyR = 3'd4;
  localparam logic [2:0] SCopyW = 3'd5;

  logic [2:0] state_q, state_d;
  logic [WordW-1:0] mem [Depth];
  logic [WordW-1:0] rdata_q;
  logic [LenW-1:0] len_q [MaxSegments];
  logic [LenW-1:0] len0_q, lenr_q;
  logic [MaxSegments-1:0] mapped_q;
  logic [SegW-1:0] stack_q [MaxSegments];
  logic [SegW-1:0] top_q;
  logic [CntW-1:0] free_q, fresh_q;
  req_t r_q;

  logic acc;
  logic [SegW-1:0] sid, did, id_q, src_q, pick;
  logic sid_ok, did_ok, have_id;
  logic [LenW-1:0] slen, cnt_q, lim_q;
  logic map_ok, un_ok, ld_ok, st_ok, dup_go, app_ok, res_set;
  logic [StatW-1:0] st_d;
  logic [WordW-1:0] rw_q;
  logic [IdW-1:0] nid_q;
  logic [StatW-1:0] st_q;
  logic res_v_q;
  logic mem_we;
  logic [AddrW-1:0] mem_wa, mem_ra;
  logic [WordW-1:0] mem_wd;
  logic len_we;
  logic [SegW-1:0] len_wa;
  logic [LenW-1:0] len_wd;

  assign acc = req_valid_i && req_ready_o;
  assign req_ready_o = (state_q == SIdle) && (!res_v_q || res_ready_i);
  assign res_valid_o = res_v_q;
  assign read_word_o = rw_q;
  assign new_id_o = nid_q;
  assign status_o = st_q;

  assign sid = r_q.seg_id[SegW-1:0];
  assign did = r_q.dest_id[SegW-1:0];
  assign sid_ok = ({{(32-IdW){1'b0}}, r_q.seg_id} < MaxSegments) && mapped_q[sid];
  assign did_ok = ({{(32-IdW){1'b0}}, r_q.dest_id} < MaxSegments) && mapped_q[did];
  assign slen = (sid == '0) ? len0_q : lenr_q;
  assign have_id = (free_q != '0) || ({{(32-CntW){1'b0}}, fresh_q} < MaxSegments);
  assign pick = (free_q != '0) ? top_q : fresh_q[SegW-1:0];

  assign map_ok = (state_q == SEval) && (r_q.req == ReqMap)
                  && ({{(32-SizeW){1'b0}}, r_q.size} <= MaxWords) && have_id;
  assign un_ok = (state_q == SEval) && (r_q.req == ReqUnmap) && sid_ok;
  assign ld_ok = (state_q == SEval) && (r_q.req == ReqLoad) && sid_ok
                 && ({{(LenW-OffW){1'b0}}, r_q.offset} < slen);
  assign st_ok = (state_q == SEval) && (r_q.req == ReqStore) && sid_ok
                 && ({{(LenW-OffW){1'b0}}, r_q.offset} < slen);
  assign dup_go = (state_q == SEval) && (r_q.req == ReqDup) && sid_ok && did_ok
                  && (sid != did);
  assign app_ok = (state_q == SEval) && (r_q.req == ReqAppend) && mapped_q[0]
                  && ({{(32-LenW){1'b0}}, len0_q} < MaxWords);

  assign res_set = ((state_q == SEval) && (state_d == SIdle)) || (state_q == SRead)
                   || ((state_q == SZero || state_q == SCopyR) && cnt_q == lim_q);

  always_comb begin
    st_d = StOk;
    unique case (r_q.req)
      ReqMap: begin
        if ({{(32-SizeW){1'b0}}, r_q.size} > MaxWords) st_d = StTooLarge;
        else if (!have_id) st_d = StNoId;
      end
      ReqUnmap: begin
        if (!sid_ok) st_d = StUnmapped;
      end
      ReqLoad, ReqStore: begin
        if (!sid_ok) st_d = StUnmapped;
        else if ({{(LenW-OffW){1'b0}}, r_q.offset} >= slen) st_d = StRange;
      end
      ReqDup: begin
        if (!sid_ok || !did_ok) st_d = StUnmapped;
      end
      ReqAppend: begin
        if (!mapped_q[0]) st_d = StUnmapped;
        else if ({{(32-LenW){1'b0}}, len0_q} >= MaxWords) st_d = StTooLarge;
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = {sid, r_q.offset[WrdW-1:0]};
    mem_wd = r_q.value;
    mem_ra = {sid, r_q.offset[WrdW-1:0]};
    if (state_q == SZero) begin
      mem_we = (cnt_q != lim_q);
      mem_wa = {id_q, cnt_q[WrdW-1:0]};
      mem_wd = '0;
    end else if (state_q == SCopyR) begin
      mem_ra = {src_q, cnt_q[WrdW-1:0]};
    end else if (state_q == SCopyW) begin
      mem_we = 1'b1;
      mem_wa = {id_q, cnt_q[WrdW-1:0]};
      mem_wd = rdata_q;
    end else if (st_ok) begin
      mem_we = 1'b1;
    end else if (app_ok) begin
      mem_we = 1'b1;
      mem_wa = {{SegW{1'b0}}, len0_q[WrdW-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_q <= mem[mem_ra];
  end

  // Segment 0 keeps its length in a register so that it reads as zero after reset.
  always_comb begin
    len_we = 1'b0;
    len_wa = pick;
    len_wd = r_q.size[LenW-1:0];
    if (map_ok) begin
      len_we = 1'b1;
    end else if (un_ok) begin
      len_we = 1'b1;
      len_wa = sid;
      len_wd = '0;
    end else if (dup_go) begin
      len_we = 1'b1;
      len_wa = did;
      len_wd = slen;
    end
  end

  always_ff @(posedge clk_i) begin
    if (len_we) len_q[len_wa] <= len_wd;
    if (acc) lenr_q <= len_q[req_i.seg_id[SegW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (un_ok) stack_q[free_q[SegW-1:0]] <= sid;
    if (acc) top_q <= stack_q[SegW'(free_q - CntW'(1))];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: if (acc) state_d = SEval;
      SEval: begin
        if (map_ok) state_d = SZero;
        else if (ld_ok) state_d = SRead;
        else if (dup_go) state_d = SCopyR;
        else state_d = SIdle;
      end
      SRead: state_d = SIdle;
      SZero: if (cnt_q == lim_q) state_d = SIdle;
      SCopyR: state_d = (cnt_q == lim_q) ? SIdle : SCopyW;
      SCopyW: state_d = SCopyR;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      mapped_q <= {{(MaxSegments-1){1'b0}}, 1'b1};
      free_q <= '0;
      fresh_q <= CntW'(1);
      len0_q <= '0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_set) res_v_q <= 1'b1;
      else if (res_v_q && res_ready_i) res_v_q <= 1'b0;
      if (map_ok) begin
        if (free_q != '0) free_q <= free_q - CntW'(1);
        else fresh_q <= fresh_q + CntW'(1);
        mapped_q[pick] <= 1'b1;
      end else if (un_ok) begin
        mapped_q[sid] <= 1'b0;
        free_q <= free_q + CntW'(1);
      end
      if (app_ok) len0_q <= len0_q + LenW'(1);
      else if (len_we && len_wa == '0) len0_q <= len_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) r_q <= req_i;
    if (state_q == SEval) begin
      rw_q <= '0;
      nid_q <= map_ok ? IdW'(pick) : '0;
      st_q <= st_d;
      cnt_q <= '0;
      if (map_ok) begin
        id_q <= pick;
        lim_q <= r_q.size[LenW-1:0];
      end else if (dup_go) begin
        id_q <= did;
        src_q <= sid;
        lim_q <= slen;
      end
    end else if (state_q == SCopyW || (state_q == SZero && cnt_q != lim_q)) begin
      cnt_q <= cnt_q + LenW'(1);
    end
    if (state_q == SRead) rw_q <= rdata_q;
  end

endmodule

// ===== rtl/core/smir_checker.sv =====
module smir_checker
  import smir_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic res_valid_o,
  input logic res_ready_i,
  input logic [WordW-1:0] read_word_o,
  input logic [IdW-1:0] new_id_o,
  input logic [StatW-1:0] status_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(status_o))
    else $error("result dropped while stalled");
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> status_o <= StTooLarge)
    else $error("bad status code");
  a_err_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_o != StOk |-> new_id_o == '0 && read_word_o == '0)
    else $error("error result carries data");

endmodule

bind segment_memory_with_id_recycling_top smir_checker u_chk (.*);

// ===== tb/segment_memory_with_id_recycling_top_tb.sv =====
`timescale 1ns / 100ps

module segment_memory_with_id_recycling_top_tb;
  import smir_pkg::*;

  localparam int NumSeg = 64;
  localparam int NumWords = 1024;
  localparam int RandItems = 1850;
  localparam longint CycleLimit = 20000000;

  typedef struct {
    logic [WordW-1:0] read_word;
    logic [IdW-1:0] new_id;
    logic [StatW-1:0] status;
  } seg_result_t;

  class seg_scoreboard;
    logic [WordW-1:0] words [NumSeg*NumWords];
    int unsigned seg_len [NumSeg];
    bit seg_live [NumSeg];
    int unsigned free_ids [NumSeg];
    int unsigned free_cnt;
    int unsigned fresh_id;
    seg_result_t pending [$];
    int errors;
    int n_checked;
    int st_seen [8];

    function new();
      foreach (seg_len[i]) begin
        seg_len[i] = 0;
        seg_live[i] = 0;
      end
      seg_live[0] = 1;
      free_cnt = 0;
      fresh_id = 1;
      errors = 0;
      n_checked = 0;
    endfunction

    function void note(logic [ReqW-1:0] req, logic [IdW-1:0] sid, logic [IdW-1:0] did,
                       logic [OffW-1:0] off, logic [SizeW-1:0] sz, logic [WordW-1:0] val);
      seg_result_t r;
      int unsigned id;
      r.read_word = '0;
      r.new_id = '0;
      r.status = StOk;
      case (req)
        ReqMap: begin
          if (sz > NumWords) begin
            r.status = StTooLarge;
          end else if (free_cnt > 0) begin
            free_cnt--;
            id = free_ids[free_cnt];
          end else if (fresh_id < NumSeg) begin
            id = fresh_id;
            fresh_id++;
          end else begin
            r.status = StNoId;
          end
          if (r.status == StOk) begin
            for (int i = 0; i < sz; i++) words[id*NumWords+i] = '0;
            seg_len[id] = 32'(sz);
            seg_live[id] = 1;
            r.new_id = IdW'(id);
          end
        end
        ReqUnmap: begin
          if (!seg_live[sid]) begin
            r.status = StUnmapped;
          end else begin
            seg_live[sid] = 0;
            seg_len[sid] = 0;
            free_ids[free_cnt] = 32'(sid);
            free_cnt++;
          end
        end
        ReqLoad, ReqStore: begin
          if (!seg_live[sid]) r.status = StUnmapped;
          else if (off >= seg_len[sid]) r.status = StRange;
          else if (req == ReqLoad) r.read_word = words[sid*NumWords+off];
          else words[sid*NumWords+off] = val;
        end
        ReqDup: begin
          if (!seg_live[sid] || !seg_live[did]) begin
            r.status = StUnmapped;
          end else if (sid != did) begin
            for (int i = 0; i < seg_len[sid]; i++)
              words[did*NumWords+i] = words[sid*NumWords+i];
            seg_len[did] = seg_len[sid];
          end
        end
        ReqAppend: begin
          if (!seg_live[0]) r.status = StUnmapped;
          else if (seg_len[0] >= NumWords) r.status = StTooLarge;
          else begin
            words[seg_len[0]] = val;
            seg_len[0]++;
          end
        end
        default: ;
      endcase
      st_seen[r.status]++;
      pending.push_back(r);
    endfunction

    function void check(logic [WordW-1:0] rd, logic [IdW-1:0] nid, logic [StatW-1:0] st);
      seg_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat rd=%h id=%0d st=%0d", $time, rd, nid, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (rd !== e.read_word) begin
        $display("%0t: read_word expected %h actual %h", $time, e.read_word, rd);
        errors++;
      end
      if (nid !== e.new_id) begin
        $display("%0t: new_id expected %0d actual %0d", $time, e.new_id, nid);
        errors++;
      end
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  logic [ReqW-1:0] req_type_i = '0;
  logic [IdW-1:0] seg_id_i = '0;
  logic [IdW-1:0] dest_id_i = '0;
  logic [OffW-1:0] offset_i = '0;
  logic [SizeW-1:0] size_i = '0;
  logic [WordW-1:0] value_i = '0;
  logic res_valid_o;
  logic res_ready_i = 1'b0;
  logic [WordW-1:0] read_word_o;
  logic [IdW-1:0] new_id_o;
  logic [StatW-1:0] status_o;

  seg_scoreboard sb = new();
  longint cycles = 0;
  bit stall_request = 0;
  bit stall_done = 0;

  segment_memory_with_id_recycling_top i_dut (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .req_type_i, .seg_id_i, .dest_id_i,
    .offset_i, .size_i, .value_i, .res_valid_o, .res_ready_i, .read_word_o,
    .new_id_o, .status_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && res_ready_i) sb.check(read_word_o, new_id_o, status_o);
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_request && !stall_done) begin
        res_ready_i = 1'b0;
        repeat (400) @(negedge clk_i);
        stall_done = 1;
      end
      g = gap_len();
      if (g == 0) begin
        res_ready_i = 1'b1;
      end else begin
        res_ready_i = 1'b0;
        repeat (g - 1) @(negedge clk_i);
      end
    end
  end

  task automatic send_req(logic [ReqW-1:0] req, logic [IdW-1:0] sid, logic [IdW-1:0] did,
                          logic [OffW-1:0] off, logic [SizeW-1:0] sz, logic [WordW-1:0] val);
    int g;
    @(negedge clk_i);
    req_type_i = req;
    seg_id_i = sid;
    dest_id_i = did;
    offset_i = off;
    size_i = sz;
    value_i = val;
    req_valid_i = 1'b1;
    do @(posedge clk_i); while (!req_ready_o);
    sb.note(req, sid, did, off, sz, val);
    g = gap_len();
    if (g > 0) begin
      @(negedge clk_i);
      req_valid_i = 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
  endtask

  function automatic logic [IdW-1:0] pick_id();
    int live [$];
    foreach (sb.seg_live[i]) if (sb.seg_live[i]) live.push_back(i);
    if (live.size() > 0 && $urandom_range(0, 99) < 80)
      return IdW'(live[$urandom_range(0, live.size() - 1)]);
    return IdW'($urandom_range(0, NumSeg - 1));
  endfunction

  function automatic logic [SizeW-1:0] pick_size();
    int p;
    p = $urandom_range(0, 999);
    if (p < 880) return SizeW'($urandom_range(0, 16));
    if (p < 960) return SizeW'($urandom_range(17, 80));
    if (p < 970) return SizeW'($urandom_range(81, NumWords));
    if (p < 975) return SizeW'(NumWords);
    return SizeW'($urandom_range(NumWords + 1, 2047));
  endfunction

  task automatic send_random();
    int p;
    logic [IdW-1:0] sid, rid, rdid;
    logic [OffW-1:0] off, roff;
    logic [SizeW-1:0] rsz;
    logic [WordW-1:0] rval;
    logic [ReqW-1:0] rreq;
    p = $urandom_range(0, 99);
    sid = pick_id();
    rid = IdW'($urandom);
    rdid = IdW'($urandom);
    roff = OffW'($urandom);
    rsz = SizeW'($urandom);
    rval = $urandom;
    rreq = ReqW'($urandom_range(6, 7));
    if (sb.seg_live[sid] && sb.seg_len[sid] > 0 && $urandom_range(0, 99) < 80)
      off = OffW'($urandom_range(0, sb.seg_len[sid] - 1));
    else
      off = roff;
    if (p < 24) send_req(ReqMap, rid, rdid, roff, pick_size(), rval);
    else if (p < 36) send_req(ReqUnmap, sid, rdid, off, rsz, rval);
    else if (p < 56) send_req(ReqLoad, sid, rdid, off, rsz, rval);
    else if (p < 76) send_req(ReqStore, sid, rdid, off, rsz, rval);
    else if (p < 84) send_req(ReqDup, sid, pick_id(), off, rsz, rval);
    else if (p < 96) send_req(ReqAppend, sid, rdid, off, rsz, rval);
    else send_req(rreq, rid, rdid, roff, rsz, rval);
  endtask

  initial begin
    int n;
    int wait_cnt;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_req(ReqMap, '0, '0, '0, 11'd0, '0);
    send_req(ReqMap, '0, '0, '0, 11'd2047, '0);
    send_req(ReqMap, '0, '0, '0, 11'd1025, '0);
    send_req(ReqMap, 6'h3f, 6'h3f, 10'h3ff, 11'd8, 32'hffff_ffff);
    send_req(ReqStore, 6'd2, '0, 10'd7, '0, 32'hffff_ffff);
    send_req(ReqStore, 6'd2, '0, 10'd0, '0, 32'h0);
    send_req(ReqLoad, 6'd2, '0, 10'd7, '0, '0);
    send_req(ReqLoad, 6'd2, '0, 10'd8, '0, '0);
    send_req(ReqLoad, 6'd2, '0, 10'h3ff, '0, '0);
    send_req(ReqLoad, 6'h3f, '0, 10'd0, '0, '0);
    send_req(ReqStore, 6'h3f, '0, 10'd0, '0, 32'h1234_5678);
    send_req(ReqAppend, '0, '0, '0, '0, 32'hdead_beef);
    send_req(ReqDup, 6'd2, 6'd2, '0, '0, '0);
    send_req(ReqDup, 6'd2, 6'd1, '0, '0, '0);
    send_req(ReqLoad, 6'd1, '0, 10'd7, '0, '0);
    send_req(ReqDup, 6'd2, 6'h3f, '0, '0, '0);
    send_req(ReqUnmap, 6'h3f, '0, '0, '0, '0);
    send_req(ReqUnmap, 6'd0, '0, '0, '0, '0);
    send_req(ReqAppend, '0, '0, '0, '0, 32'h5555_aaaa);
    send_req(ReqMap, '0, '0, '0, 11'd1024, '0);
    send_req(ReqLoad, 6'd0, '0, 10'h3ff, '0, '0);
    send_req(ReqAppend, '0, '0, '0, '0, 32'h1);
    send_req(3'd6, 6'h3f, 6'h3f, 10'h3ff, 11'h7ff, 32'hffff_ffff);
    send_req(3'd7, '0, '0, '0, '0, '0);

    n = 0;
    while (n < RandItems) begin
      if (n == 600) stall_request = 1;
      if (n == 1200) begin
        @(negedge clk_i);
        req_valid_i = 1'b0;
        wait (sb.pending.size() == 0);
      end
      send_random();
      n++;
    end
    @(negedge clk_i);
    req_valid_i = 1'b0;

    wait (sb.pending.size() == 0);
    repeat (4200) @(posedge clk_i);

    $display("Checked %0d results: ok %0d, no-id %0d, unmapped %0d, range %0d, too-large %0d.",
             sb.n_checked, sb.st_seen[StOk], sb.st_seen[StNoId], sb.st_seen[StUnmapped],
             sb.st_seen[StRange], sb.st_seen[StTooLarge]);
    $display("Run included a long result stall and a drained pause, %0d cycles.", cycles);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/smir_pkg.sv
rtl/core/smir_req_fifo.sv
rtl/core/smir_engine.sv
rtl/core/segment_memory_with_id_recycling_top.sv
rtl/core/smir_checker.sv
tb/segment_memory_with_id_recycling_top_tb.sv
